FILE: sv/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg - shared types and constants of the piecewise cubic sine
// Q32 angle constants, segment bounds, Q30 cubic coefficients and the
// control word that travels with each item down the polynomial pipeline.
// ----------------------------------------------------------------------------
package pcs_pkg;

	localparam int NSEG  = 7;
	localparam int SEG_W = 3;
	localparam int T30_W = 31;   // folded angle, Q30, unsigned
	localparam int ACC_W = 34;   // Horner accumulator, Q30, signed
	localparam int R_W   = 35;   // reduced angle, Q32, unsigned
	localparam int T_W   = 33;   // folded angle, Q32, unsigned

	localparam longint TWO_PI_Q32 = 64'sd26986075409;

	localparam logic [R_W-1:0] HALF_PI       = 35'd6746518852;
	localparam logic [R_W-1:0] PI            = 35'd13493037705;
	localparam logic [R_W-1:0] THREE_HALF_PI = 35'd20239556557;
	localparam logic [R_W-1:0] TWO_PI        = R_W'(TWO_PI_Q32);

	// 1e-9 units to Q32, rounded to nearest
	function automatic longint bound_q32(input longint b);
		return (b * 64'sd8388608 + 64'sd976562) / 64'sd1953125;
	endfunction

	// 1e-13 units to Q30, rounded to nearest, magnitude first
	function automatic longint coef_q30(input longint c);
		longint mag;
		longint q;
		mag = (c < 0) ? -c : c;
		q   = (mag * 64'sd131072 + 64'sd610351562) / 64'sd1220703125;
		return (c < 0) ? -q : q;
	endfunction

	localparam logic [T_W-1:0] BOUND [NSEG] = '{
		T_W'(bound_q32(64'sd349065850)),  T_W'(bound_q32(64'sd523598776)),
		T_W'(bound_q32(64'sd698131701)),  T_W'(bound_q32(64'sd872664626)),
		T_W'(bound_q32(64'sd1047197551)), T_W'(bound_q32(64'sd1221730476)),
		T_W'(bound_q32(64'sd1570796327))
	};

	localparam logic signed [ACC_W-1:0] COEF [NSEG][4] = '{
		'{ACC_W'(coef_q30(-64'sd1622577489580)), ACC_W'(coef_q30(-64'sd16459527368)),
		  ACC_W'(coef_q30(64'sd10001606966700)), ACC_W'(coef_q30(64'sd0))},
		'{ACC_W'(coef_q30(-64'sd1509651715040)), ACC_W'(coef_q30(-64'sd134715121937)),
		  ACC_W'(coef_q30(64'sd10042885956400)), ACC_W'(coef_q30(-64'sd4803028546))},
		'{ACC_W'(coef_q30(-64'sd1367440765250)), ACC_W'(coef_q30(-64'sd358099559493)),
		  ACC_W'(coef_q30(64'sd10159849774400)), ACC_W'(coef_q30(-64'sd25217065842))},
		'{ACC_W'(coef_q30(-64'sd1180966085560)), ACC_W'(coef_q30(-64'sd748651215345)),
		  ACC_W'(coef_q30(64'sd10432506266200)), ACC_W'(coef_q30(-64'sd88667112615))},
		'{ACC_W'(coef_q30(-64'sd952882457585)), ACC_W'(coef_q30(-64'sd1345772757060)),
		  ACC_W'(coef_q30(64'sd10953593113000)), ACC_W'(coef_q30(-64'sd240245132062))},
		'{ACC_W'(coef_q30(-64'sd721464278044)), ACC_W'(coef_q30(-64'sd2072794409820)),
		  ACC_W'(coef_q30(64'sd11714928407500)), ACC_W'(coef_q30(-64'sd506001284052))},
		'{ACC_W'(coef_q30(-64'sd371377463960)), ACC_W'(coef_q30(-64'sd3355929600270)),
		  ACC_W'(coef_q30(64'sd13282573775000)), ACC_W'(coef_q30(-64'sd1144414657940))}
	};

	typedef struct packed {
		logic             valid;
		logic             hit;
		logic             neg;
		logic [SEG_W-1:0] seg;
		logic [T30_W-1:0] t30;
	} pcs_ctl_t;

endpackage

FILE: sv/piecewise_cubic_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_cubic_sine - fixed-point sine by seven-segment cubic
// One item a cycle, so busy stays low and results follow each other back
// to back. Six front stages reduce, fold and classify the angle, each
// Horner step takes two stages and one output register closes the pipe.
// Reset clears the valid bits and control words; the result ports cannot be
// stalled.
// ----------------------------------------------------------------------------
module piecewise_cubic_sine #(
	parameter int ANGLE_FRAC_BITS  = 24,
	parameter int RESULT_FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] sine_value
);
	import pcs_pkg::*;

	// Angle scale to Q32 and width of the scaled angle
	localparam int S   = 32 - ANGLE_FRAC_BITS;
	localparam int RMW = 32 + S + 2;
	// Quotient estimate: width and reciprocal of 2*pi, scaled by 2^(S+SH)
	localparam int QW  = S - 1;
	localparam int SH  = 40;
	localparam longint RECIP_L = ((64'sd1 <<< (S + SH)) + TWO_PI_Q32 / 2) / TWO_PI_Q32;
	localparam logic signed [31:0] RECIP    = 32'(RECIP_L);
	localparam logic signed [35:0] TWO_PI_S = 36'(TWO_PI_Q32);
	// Output rounding from Q30 to the result format
	localparam int N   = 30 - RESULT_FRAC_BITS;
	localparam logic signed [35:0] RND      = 36'((64'sd1 <<< N) >>> 1);
	localparam logic signed [35:0] SAT_HI   = 36'sd2147483647;
	localparam logic signed [35:0] SAT_LO   = -36'sd2147483648;
	localparam int LAT = 13;

	// Stage 1: reciprocal estimate of the turn count
	logic                    vld_s1;
	logic signed [31:0]      a_s1;
	logic signed [63:0]      prod_s1;
	// Stage 2: whole turns in Q32
	logic                    vld_s2;
	logic signed [31:0]      a_s2;
	logic signed [QW+35:0]   qp_s2;
	// Stage 3: raw remainder, may be one turn off
	logic                    vld_s3;
	logic signed [RMW-1:0]   rem_s3;
	// Stage 4: remainder in [0, 2*pi)
	logic                    vld_s4;
	logic [R_W-1:0]          r_s4;
	// Stage 5: folded angle and sign
	logic                    vld_s5;
	logic [T_W-1:0]          t_s5;
	logic                    neg_s5;
	// Stage 6: segment and Q30 angle
	pcs_ctl_t                ctl_s6;
	// Horner steps
	pcs_ctl_t                ctl_h1, ctl_h2, ctl_h3;
	logic signed [ACC_W-1:0] acc_h1, acc_h2, acc_h3;
	// Stage 13: output register
	logic                    vld_s13;
	logic signed [31:0]      res_s13;

	logic signed [QW-1:0]    q_est;
	logic signed [RMW-1:0]   rem_c;
	logic [R_W-1:0]          r_c;
	logic [R_W-1:0]          t_c;
	logic                    neg_c;
	logic [SEG_W-1:0]        seg_c;
	logic                    hit_c;
	logic [T30_W-1:0]        t30_c;
	logic signed [35:0]      fin_v;
	logic signed [35:0]      fin_r;
	logic signed [31:0]      res_c;

	// No back-pressure anywhere: an item may enter every cycle
	assign busy = 1'b0;

	// Floor of the estimate; off by at most one turn either way
	assign q_est = prod_s1[SH+QW-1:SH];
	assign rem_c = (RMW'(a_s2) <<< S) - RMW'(qp_s2);

	// Pull the remainder back into one turn
	always_comb begin
		if (rem_s3 < 0) begin
			r_c = R_W'(rem_s3 + RMW'(TWO_PI));
		end else if (rem_s3 >= RMW'(TWO_PI)) begin
			r_c = R_W'(rem_s3 - RMW'(TWO_PI));
		end else begin
			r_c = R_W'(rem_s3);
		end
	end

	// Quadrant fold into 0..pi/2; lower half-plane gives a negative sign
	always_comb begin
		if (r_s4 < HALF_PI) begin
			t_c   = r_s4;
			neg_c = 1'b0;
		end else if (r_s4 < PI) begin
			t_c   = PI - r_s4;
			neg_c = 1'b0;
		end else if (r_s4 < THREE_HALF_PI) begin
			t_c   = r_s4 - PI;
			neg_c = 1'b1;
		end else begin
			t_c   = TWO_PI - r_s4;
			neg_c = 1'b1;
		end
	end

	// First bound above the angle wins; the last segment also takes its bound
	always_comb begin
		seg_c = '0;
		hit_c = 1'b0;
		for (int i = NSEG - 1; i >= 0; i--) begin
			if ((i < NSEG - 1) ? (t_s5 < BOUND[i]) : (t_s5 <= BOUND[i])) begin
				seg_c = SEG_W'(i);
				hit_c = 1'b1;
			end
		end
	end

	assign t30_c = T30_W'((34'(t_s5) + 34'd2) >> 2);

	// Drop a miss to zero, apply sign, round to the result format, saturate
	always_comb begin
		fin_v = ctl_h3.hit ? 36'(acc_h3) : '0;
		if (ctl_h3.neg) begin
			fin_v = -fin_v;
		end
		fin_r = (fin_v + RND) >>> N;
		if (fin_r > SAT_HI) begin
			res_c = 32'(SAT_HI);
		end else if (fin_r < SAT_LO) begin
			res_c = 32'(SAT_LO);
		end else begin
			res_c = 32'(fin_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			vld_s5       <= 1'b0;
			ctl_s6       <= '0;
			vld_s13      <= 1'b0;
		end else begin
			vld_s1       <= start && !busy;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_s5       <= vld_s4;
			ctl_s6.valid <= vld_s5;
			ctl_s6.hit   <= hit_c;
			ctl_s6.neg   <= neg_s5;
			ctl_s6.seg   <= seg_c;
			ctl_s6.t30   <= t30_c;
			vld_s13      <= ctl_h3.valid;
		end
	end

	// Payload advances every cycle; the valid bits say what is real
	always_ff @(posedge clk) begin
		a_s1       <= angle;
		prod_s1    <= 64'(angle) * 64'(RECIP);
		a_s2       <= a_s1;
		qp_s2      <= (QW+36)'(q_est) * (QW+36)'(TWO_PI_S);
		rem_s3     <= rem_c;
		r_s4       <= r_c;
		t_s5       <= T_W'(t_c);
		neg_s5     <= neg_c;
		res_s13    <= res_c;
	end

	// Horner's rule: leading coefficient enters the first step straight
	// from the table
	pcs_horner_step #(.STEP(1)) u_step1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s6),
		.acc_in  (COEF[ctl_s6.seg][0]),
		.ctl_out (ctl_h1),
		.acc_out (acc_h1)
	);

	pcs_horner_step #(.STEP(2)) u_step2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_h1),
		.acc_in  (acc_h1),
		.ctl_out (ctl_h2),
		.acc_out (acc_h2)
	);

	pcs_horner_step #(.STEP(3)) u_step3 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_h2),
		.acc_in  (acc_h2),
		.ctl_out (ctl_h3),
		.acc_out (acc_h3)
	);

	assign done       = vld_s13;
	assign sine_value = res_s13;

	// Every accepted item is followed by its done strobe
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item did not emerge after fixed latency");

	// No result without a matching accepted item
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without matching item");

	// One correction step must leave the remainder inside a single turn
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (r_s4 < TWO_PI))
		else $error("angle reduction out of range");

	// Folded angle never exceeds the last bound, so a segment is always hit
	a_seg_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s6.valid |-> ctl_s6.hit)
		else $error("folded angle beyond last segment");

endmodule

FILE: sv/pcs_horner_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_horner_step - one Horner step of the segment cubic
// Multiply the accumulator by the folded angle, then round the product back
// to Q30 and add the next coefficient of the item's segment. Two stages.
// ----------------------------------------------------------------------------
module pcs_horner_step #(
	parameter int STEP = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pcs_pkg::pcs_ctl_t                  ctl_in,
	input  logic signed [pcs_pkg::ACC_W-1:0]   acc_in,
	output pcs_pkg::pcs_ctl_t                  ctl_out,
	output logic signed [pcs_pkg::ACC_W-1:0]   acc_out
);
	import pcs_pkg::*;

	localparam int P_W = ACC_W + T30_W + 1;
	localparam logic signed [P_W-1:0] HALF_LSB = P_W'(64'sd1 <<< 29);

	pcs_ctl_t                 ctl_s1;
	logic signed [P_W-1:0]    prod_s1;
	logic signed [P_W-1:0]    prod_rnd;
	logic signed [ACC_W-1:0]  acc_s2;
	pcs_ctl_t                 ctl_s2;

	// round half up, back to Q30
	assign prod_rnd = (prod_s1 + HALF_LSB) >>> 30;

	// Control word advances with its valid bit; clear both stages on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1    <= P_W'(acc_in) * P_W'(signed'({1'b0, ctl_in.t30}));
		acc_s2     <= ACC_W'(prod_rnd) + COEF[ctl_s1.seg][STEP];
	end

	assign ctl_out = ctl_s2;
	assign acc_out = acc_s2;

endmodule

FILE: tb/piecewise_cubic_sine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_cubic_sine_checker - sine predictor and result scoreboard
// Watches the command and result channels of the sine block. Computes the
// expected sine for every accepted angle and compares each done strobe
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module piecewise_cubic_sine_checker #(
	parameter int ANGLE_FRAC_BITS  = 24,
	parameter int RESULT_FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] angle,
	input  logic               done,
	input  logic signed [31:0] sine_value,
	output int                 fail_count,
	output int                 pending
);

	localparam int WORK_FRAC = 32;
	localparam int POLY_FRAC = 30;

	localparam longint Q32_HALF_PI       = 64'sd6746518852;
	localparam longint Q32_PI            = 64'sd13493037705;
	localparam longint Q32_THREE_HALF_PI = 64'sd20239556557;
	localparam longint Q32_TWO_PI        = 64'sd26986075409;

	// segment upper bounds, 1e-9 rad
	localparam longint SEG_END_E9 [7] = '{
		64'sd349065850, 64'sd523598776, 64'sd698131701, 64'sd872664626,
		64'sd1047197551, 64'sd1221730476, 64'sd1570796327
	};

	// cubic coefficients a, b, c, d per segment, 1e-13 units
	localparam longint CUBIC_E13 [7][4] = '{
		'{-64'sd1622577489580, -64'sd16459527368, 64'sd10001606966700, 64'sd0},
		'{-64'sd1509651715040, -64'sd134715121937, 64'sd10042885956400,
		  -64'sd4803028546},
		'{-64'sd1367440765250, -64'sd358099559493, 64'sd10159849774400,
		  -64'sd25217065842},
		'{-64'sd1180966085560, -64'sd748651215345, 64'sd10432506266200,
		  -64'sd88667112615},
		'{-64'sd952882457585, -64'sd1345772757060, 64'sd10953593113000,
		  -64'sd240245132062},
		'{-64'sd721464278044, -64'sd2072794409820, 64'sd11714928407500,
		  -64'sd506001284052},
		'{-64'sd371377463960, -64'sd3355929600270, 64'sd13282573775000,
		  -64'sd1144414657940}
	};

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] sine;
	} sine_pred_t;

	sine_pred_t expected_sine [$];

	assign pending = expected_sine.size();

	// round half up, then drop n bits
	function automatic longint shr_round(input longint v, input int n);
		if (n == 0)
			return v;
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// 1e-9 rad to Q32: times 2^23 over 5^9, nearest
	function automatic longint rad_e9_to_q32(input longint b);
		return (b * 64'sd8388608 + 64'sd1953125 / 2) / 64'sd1953125;
	endfunction

	// 1e-13 units to Q30: times 2^17 over 5^13, nearest on the magnitude
	function automatic longint e13_to_q30(input longint c);
		longint mag;
		longint q;
		mag = (c < 0) ? -c : c;
		q   = (mag * 64'sd131072 + 64'sd1220703125 / 2) / 64'sd1220703125;
		return (c < 0) ? -q : q;
	endfunction

	function automatic logic signed [31:0] sine_of_angle(input logic signed [31:0] ang);
		longint r;
		longint t;
		longint t30;
		longint acc;
		longint res;
		longint lim;
		bit     neg;
		int     seg;
		r = longint'(ang) * (64'sd1 <<< (WORK_FRAC - ANGLE_FRAC_BITS));
		r = r % Q32_TWO_PI;
		if (r < 0)
			r = r + Q32_TWO_PI;
		if (r < Q32_HALF_PI) begin
			t = r; neg = 1'b0;
		end else if (r < Q32_PI) begin
			t = Q32_PI - r; neg = 1'b0;
		end else if (r < Q32_THREE_HALF_PI) begin
			t = r - Q32_PI; neg = 1'b1;
		end else begin
			t = Q32_TWO_PI - r; neg = 1'b1;
		end
		seg = -1;
		for (int i = 0; i < 7; i++) begin
			lim = rad_e9_to_q32(SEG_END_E9[i]);
			if (seg < 0 && ((i < 6) ? (t < lim) : (t <= lim)))
				seg = i;
		end
		acc = 0;
		if (seg >= 0) begin
			t30 = shr_round(t, WORK_FRAC - POLY_FRAC);
			acc = e13_to_q30(CUBIC_E13[seg][0]);
			for (int k = 1; k < 4; k++)
				acc = shr_round(acc * t30, POLY_FRAC) + e13_to_q30(CUBIC_E13[seg][k]);
		end
		if (neg)
			acc = -acc;
		res = shr_round(acc, POLY_FRAC - RESULT_FRAC_BITS);
		if (res > 64'sd2147483647)
			res = 64'sd2147483647;
		if (res < -64'sd2147483648)
			res = -64'sd2147483648;
		return 32'(res);
	endfunction

	initial fail_count = 0;

	always @(posedge clk) begin
		sine_pred_t head;
		sine_pred_t item;
		if (arst_n) begin
			if (done) begin
				if (expected_sine.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %0d",
						$time, sine_value);
					fail_count = fail_count + 1;
				end else begin
					head = expected_sine.pop_front();
					if (sine_value !== head.sine) begin
						$display("%0t: sine_value mismatch for angle %0d: expected %0d, actual %0d",
							$time, head.angle, head.sine, sine_value);
						fail_count = fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				item.angle = angle;
				item.sine  = sine_of_angle(angle);
				expected_sine.push_back(item);
			end
		end
	end

endmodule

FILE: tb/piecewise_cubic_sine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_cubic_sine_tb - stimulus and verdict for the sine block
// Drives directed angles at the quadrant and segment edges and the field
// extremes, then bursts of random angles with random gaps. The checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module piecewise_cubic_sine_tb;

	localparam int     N_RANDOM    = 1450;
	localparam int     CYCLE_LIMIT = 200000;
	// Q24 angle constants, rounded
	localparam int     HALF_PI_Q24 = 26353589;
	localparam int     PI_Q24      = 52707179;
	localparam int     TWO_PI_Q24  = 105414357;
	localparam longint SEG_END_E9 [7] = '{
		64'sd349065850, 64'sd523598776, 64'sd698131701, 64'sd872664626,
		64'sd1047197551, 64'sd1221730476, 64'sd1570796327
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic signed [31:0] angle;
	logic               busy;
	logic               done;
	logic signed [31:0] sine_value;
	int                 fail_count;
	int                 pending;
	int                 cycles;

	piecewise_cubic_sine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.angle     (angle),
		.busy      (busy),
		.done      (done),
		.sine_value(sine_value)
	);

	piecewise_cubic_sine_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.angle     (angle),
		.done      (done),
		.sine_value(sine_value),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: drop the run if the pipeline ever stops draining.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Present one item and hold it until the block takes it. Busy is read at
	// the falling edge, where it is settled for the coming rising edge.
	task automatic send_angle(input logic signed [31:0] v);
		start <= 1'b1;
		angle <= v;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Pick one random angle: full-range noise, one turn either way, hugging a
	// quadrant edge, or hugging a segment edge folded into any quadrant.
	function automatic logic signed [31:0] random_angle();
		int     k;
		int     i;
		longint v;
		case ($urandom_range(0, 3))
			0: v = longint'($signed($urandom()));
			1: v = longint'($urandom_range(0, 2 * TWO_PI_Q24)) - TWO_PI_Q24;
			2: begin
				k = int'($urandom_range(0, 160)) - 80;
				v = longint'(k) * HALF_PI_Q24 + longint'($urandom_range(0, 64)) - 32;
			end
			default: begin
				i = $urandom_range(0, 6);
				k = int'($urandom_range(0, 40)) - 20;
				v = (SEG_END_E9[i] * 64'sd16777216) / 64'sd1000000000
					+ longint'($urandom_range(0, 8)) - 4;
				if ($urandom_range(0, 1))
					v = -v;
				v = v + longint'(k) * PI_Q24;
			end
		endcase
		return 32'(v);
	endfunction

	initial begin
		int     sent;
		int     burst;
		int     gap;
		longint seg_q24;

		// Drive every input known from time zero, then hold and release reset.
		arst_n = 1'b0;
		start  = 1'b0;
		angle  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero, and each quadrant boundary.
		send_angle(32'sd0);
		send_angle(32'sd1);
		send_angle(-32'sd1);
		send_angle(32'h7fffffff);
		send_angle(32'sh80000000);
		send_angle(32'(HALF_PI_Q24));
		send_angle(32'(PI_Q24));
		send_angle(32'(3 * HALF_PI_Q24));
		send_angle(32'(TWO_PI_Q24));
		send_angle(32'(-HALF_PI_Q24));
		send_angle(32'(-PI_Q24));
		// Directed: both sides of every segment edge; the last one sits at
		// the top of the fold, where the closing bound is inclusive.
		for (int i = 0; i < 7; i++) begin
			seg_q24 = (SEG_END_E9[i] * 64'sd16777216) / 64'sd1000000000;
			send_angle(32'(seg_q24));
			send_angle(32'(seg_q24 + 1));
		end
		start <= 1'b0;
		@(posedge clk);

		// Random bursts with random gaps; some bursts run long with no gap.
		sent = 0;
		while (sent < N_RANDOM) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
			for (int j = 0; j < burst && sent < N_RANDOM; j++) begin
				send_angle(random_angle());
				sent++;
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;

		// Drain: wait for every prediction to be met, then let the pipeline
		// settle in case a stray strobe follows.
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/pcs_pkg.sv
sv/pcs_horner_step.sv
sv/piecewise_cubic_sine.sv
tb/piecewise_cubic_sine_checker.sv
tb/piecewise_cubic_sine_tb.sv
